// ===== design/aldd_pkg.sv =====
`timescale 1ns / 1ps

package aldd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned SkipW = 12;
  localparam int unsigned CountW = 32;
  localparam int unsigned CharW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNT_MODE    = 3'd0,
    CFG_SHOW_REPEATED = 3'd1,
    CFG_SHOW_UNIQUE   = 3'd2,
    CFG_SKIP_FIELDS   = 3'd3,
    CFG_SKIP_CHARS    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] group_count;
    logic              print_with_count;
    logic              print_line;
    logic              key_truncated;
  } result_t;

  localparam logic [CharW-1:0] CharSpace = 8'd32;
  localparam logic [CharW-1:0] CharTab = 8'd9;
  localparam logic [CharW-1:0] CharCr = 8'd13;

endpackage

// ===== design/aldd_result_q.sv =====
`timescale 1ns / 1ps

module aldd_result_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  aldd_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aldd_pkg::result_t out_data_o
);

  aldd_pkg::result_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/adjacent_line_dedup.sv =====
// Collapses runs of adjacent duplicate lines. Text enters one byte per transfer, the last
// byte of each line flagged with line_end_i; a transfer with stream_end_i closes the final
// group and returns the group state to its reset values (configuration registers are kept).
// One byte is taken every cycle: the front end runs the field and character skipping and
// issues a key store read, the second stage compares against the previous group's key and
// writes the new one, and each closed group leaves through a two-entry result queue, so the
// input only stalls when that queue is full. A closing byte is registered into the second
// stage, its result then into the queue. The key store holds two banks of LINE_CAP bytes
// with one read and one write port each, and needs no clearing pass after reset.
`timescale 1ns / 1ps

module adjacent_line_dedup #(
  parameter int unsigned LINE_CAP = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [aldd_pkg::CharW-1:0]          char_code_i,
  input  logic                                line_end_i,
  input  logic                                stream_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [aldd_pkg::CountW-1:0]         group_count_o,
  output logic                                print_with_count_o,
  output logic                                print_line_o,
  output logic                                key_truncated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aldd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [aldd_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(LINE_CAP);
  localparam int unsigned LW = $clog2(LINE_CAP + 1);
  localparam logic [LW-1:0] CapLen = LW'(LINE_CAP);

  // configuration
  logic                      count_mode_q, show_rep_q, show_uni_q;
  logic [aldd_pkg::SkipW-1:0] skip_fields_q, skip_chars_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mode_q  <= 1'b0;
      show_rep_q    <= 1'b1;
      show_uni_q    <= 1'b1;
      skip_fields_q <= '0;
      skip_chars_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (aldd_pkg::cfg_idx_e'(cfg_index_i))
        aldd_pkg::CFG_COUNT_MODE:    count_mode_q  <= cfg_data_i[0];
        aldd_pkg::CFG_SHOW_REPEATED: show_rep_q    <= cfg_data_i[0];
        aldd_pkg::CFG_SHOW_UNIQUE:   show_uni_q    <= cfg_data_i[0];
        aldd_pkg::CFG_SKIP_FIELDS:   skip_fields_q <= cfg_data_i[aldd_pkg::SkipW-1:0];
        aldd_pkg::CFG_SKIP_CHARS:    skip_chars_q  <= cfg_data_i[aldd_pkg::SkipW-1:0];
        default: ;
      endcase
    end
  end

  // front end: skipping and key position
  logic                       in_fire;
  logic [aldd_pkg::SkipW-1:0] fields_left_q, fields_left_d;
  logic [aldd_pkg::SkipW-1:0] chars_left_q, chars_left_d;
  logic                       inside_q, inside_d;
  logic [LW-1:0]              len_q, len_d, len_key;
  logic                       is_blank, take, keep, over;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    fields_left_d = fields_left_q;
    chars_left_d  = chars_left_q;
    inside_d      = inside_q;
    len_d         = len_q;
    len_key       = len_q;
    take          = 1'b0;
    keep          = 1'b0;
    over          = 1'b0;
    is_blank      = (char_code_i == aldd_pkg::CharSpace) ||
                    ((char_code_i >= aldd_pkg::CharTab) && (char_code_i <= aldd_pkg::CharCr));
    if (!stream_end_i) begin
      priority if (fields_left_q != '0) begin
        if (is_blank) begin
          if (inside_q) begin
            inside_d      = 1'b0;
            fields_left_d = fields_left_q - 1'b1;
          end
        end else begin
          inside_d = 1'b1;
        end
      end else if (chars_left_q != '0) begin
        chars_left_d = chars_left_q - 1'b1;
      end else begin
        take = 1'b1;
      end
      if (take) begin
        if (len_q >= CapLen) begin
          over = 1'b1;
        end else begin
          keep    = 1'b1;
          len_key = len_q + 1'b1;
          len_d   = len_key;
        end
      end
    end
    // start a new line
    if (stream_end_i || line_end_i) begin
      fields_left_d = skip_fields_q;
      chars_left_d  = skip_chars_q;
      inside_d      = 1'b0;
      len_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_left_q <= '0;
      chars_left_q  <= '0;
      inside_q      <= 1'b0;
      len_q         <= '0;
    end else if (in_fire) begin
      fields_left_q <= fields_left_d;
      chars_left_q  <= chars_left_d;
      inside_q      <= inside_d;
      len_q         <= len_d;
    end
  end

  // second stage registers
  logic                       s2_valid_q;
  logic                       s2_se_q, s2_le_q, s2_keep_q, s2_over_q;
  logic [AW-1:0]              s2_addr_q;
  logic [aldd_pkg::CharW-1:0] s2_char_q;
  logic [LW-1:0]              s2_len_q;
  logic                       s2_move, fifo_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_fire) begin
      s2_valid_q <= 1'b1;
    end else if (s2_move) begin
      s2_valid_q <= 1'b0;
    end
  end

  // carry the key length of the line including this byte
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s2_se_q   <= stream_end_i;
      s2_le_q   <= line_end_i;
      s2_keep_q <= keep;
      s2_over_q <= over;
      s2_addr_q <= len_q[AW-1:0];
      s2_char_q <= char_code_i;
      s2_len_q  <= len_key;
    end
  end

  // hold the stage while a closing item finds the result queue full
  assign s2_move    = s2_valid_q && (!(s2_se_q || s2_le_q) || !fifo_full);
  assign in_ready_o = !s2_valid_q || s2_move;

  // key store: two banks, same address read from both
  logic [aldd_pkg::CharW-1:0] bank0_mem [LINE_CAP];
  logic [aldd_pkg::CharW-1:0] bank1_mem [LINE_CAP];
  logic [aldd_pkg::CharW-1:0] rd0_q, rd1_q;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en, wr_bank, sel_q;

  assign rd_addr = len_q[AW-1:0];
  assign wr_en   = s2_move && !s2_se_q && s2_keep_q;
  assign wr_bank = ~sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_bank) begin
      bank0_mem[s2_addr_q] <= s2_char_q;
    end
    if (wr_en && wr_bank) begin
      bank1_mem[s2_addr_q] <= s2_char_q;
    end
  end

  // forward a write that lands on the address being read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (wr_en && !wr_bank && (s2_addr_q == rd_addr)) begin
        rd0_q <= s2_char_q;
      end else begin
        rd0_q <= bank0_mem[rd_addr];
      end
      if (wr_en && wr_bank && (s2_addr_q == rd_addr)) begin
        rd1_q <= s2_char_q;
      end else begin
        rd1_q <= bank1_mem[rd_addr];
      end
    end
  end

  // group state
  logic [LW-1:0]               prev_len_q, prev_len_d;
  logic                        sel_d;
  logic                        key_diff_q, key_diff_d;
  logic                        line_trunc_q, line_trunc_d;
  logic [aldd_pkg::CountW-1:0] count_q, count_d;
  logic                        have_prev_q, have_prev_d;
  logic                        trunc_seen_q, trunc_seen_d;
  logic                        emit;
  logic                        diff_now, trunc_now, differs;
  logic [aldd_pkg::CharW-1:0]  prev_byte;
  aldd_pkg::result_t           result;

  always_comb begin
    sel_d        = sel_q;
    prev_len_d   = prev_len_q;
    key_diff_d   = key_diff_q;
    line_trunc_d = line_trunc_q;
    count_d      = count_q;
    have_prev_d  = have_prev_q;
    trunc_seen_d = trunc_seen_q;
    emit         = 1'b0;
    differs      = 1'b0;
    prev_byte    = sel_q ? rd1_q : rd0_q;
    diff_now     = key_diff_q;
    trunc_now    = line_trunc_q || s2_over_q;
    if (s2_keep_q &&
        !((LW'(s2_addr_q) < prev_len_q) && (prev_byte == s2_char_q))) begin
      diff_now = 1'b1;
    end
    if (s2_se_q) begin
      emit         = have_prev_q;
      sel_d        = 1'b0;
      prev_len_d   = '0;
      key_diff_d   = 1'b0;
      line_trunc_d = 1'b0;
      count_d      = '0;
      have_prev_d  = 1'b0;
      trunc_seen_d = 1'b0;
    end else if (s2_le_q) begin
      differs      = diff_now || (s2_len_q != prev_len_q);
      key_diff_d   = 1'b0;
      line_trunc_d = 1'b0;
      if (!have_prev_q || differs) begin
        emit         = have_prev_q;
        sel_d        = ~sel_q;
        prev_len_d   = s2_len_q;
        count_d      = aldd_pkg::CountW'(1);
        trunc_seen_d = trunc_now;
        have_prev_d  = 1'b1;
      end else begin
        if (count_q != '1) begin
          count_d = count_q + 1'b1;
        end
        trunc_seen_d = trunc_seen_q || trunc_now;
      end
    end else begin
      key_diff_d   = diff_now;
      line_trunc_d = trunc_now;
    end

    result.group_count      = count_q;
    result.print_with_count = count_mode_q;
    result.print_line       = !count_mode_q &&
                              ((show_rep_q && (count_q > aldd_pkg::CountW'(1))) ||
                               (show_uni_q && (count_q == aldd_pkg::CountW'(1))));
    result.key_truncated    = trunc_seen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q        <= 1'b0;
      prev_len_q   <= '0;
      key_diff_q   <= 1'b0;
      line_trunc_q <= 1'b0;
      count_q      <= '0;
      have_prev_q  <= 1'b0;
      trunc_seen_q <= 1'b0;
    end else if (s2_move) begin
      sel_q        <= sel_d;
      prev_len_q   <= prev_len_d;
      key_diff_q   <= key_diff_d;
      line_trunc_q <= line_trunc_d;
      count_q      <= count_d;
      have_prev_q  <= have_prev_d;
      trunc_seen_q <= trunc_seen_d;
    end
  end

  // result queue
  logic              push;
  aldd_pkg::result_t out_data;

  assign push = s2_move && emit;

  aldd_result_q u_result_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign group_count_o      = out_data.group_count;
  assign print_with_count_o = out_data.print_with_count;
  assign print_line_o       = out_data.print_line;
  assign key_truncated_o    = out_data.key_truncated;

  // checks
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("result pushed into full queue");

  a_open_group_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_prev_q |-> (count_q != '0))
    else $error("open group with zero count");

  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_move && s2_se_q) |=> (!have_prev_q && (len_q == '0 || $past(in_fire))))
    else $error("stream end did not clear group state");

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s2_valid_q && fifo_full))
    else $error("input stalled without a held item and a full queue");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int LineCap = 2048;
  localparam int CycleLimit = 50000;
  localparam int DrainLimit = 5000;
  localparam int SettleCycles = 8;
  localparam logic [aldd_pkg::CharW-1:0] LineFeed = 8'h0A;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [aldd_pkg::CharW-1:0]    char_code_i = '0;
  logic                          line_end_i = 1'b0;
  logic                          stream_end_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [aldd_pkg::CountW-1:0]   group_count_o;
  logic                          print_with_count_o;
  logic                          print_line_o;
  logic                          key_truncated_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [aldd_pkg::CfgIdxW-1:0]  cfg_index_i = aldd_pkg::CFG_COUNT_MODE;
  logic [aldd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  adjacent_line_dedup #(
    .LINE_CAP(LineCap)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .char_code_i       (char_code_i),
    .line_end_i        (line_end_i),
    .stream_end_i      (stream_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .group_count_o     (group_count_o),
    .print_with_count_o(print_with_count_o),
    .print_line_o      (print_line_o),
    .key_truncated_o   (key_truncated_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Test control
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int stall_req = 0;
  int stall_left = 0;

  // Shadow registers
  bit            reg_count_mode = 1'b0;
  bit            reg_show_rep = 1'b1;
  bit            reg_show_uniq = 1'b1;
  logic [11:0]   reg_skip_fields = '0;
  logic [11:0]   reg_skip_chars = '0;

  // Predicted block state
  bit [7:0]      key_mem [0:2*LineCap-1];
  bit            bank_sel = 1'b0;
  int unsigned   stored_len = 0;
  int unsigned   key_len = 0;
  logic [11:0]   skip_field_cnt = '0;
  logic [11:0]   skip_char_cnt = '0;
  bit            in_word = 1'b0;
  bit            key_mismatch = 1'b0;
  bit            have_group = 1'b0;
  bit            group_trunc = 1'b0;
  bit            line_trunc = 1'b0;
  logic [31:0]   group_lines = '0;

  aldd_pkg::result_t pending_groups[$];
  aldd_pkg::result_t head_group;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("t=%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random idling, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(rx_idle_on && $urandom_range(0, 99) < 22);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("t=%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_groups.size() == 0) begin
        mismatches++;
        $display("t=%0t: group result expected none actual count %0d", $time,
                 group_count_o);
      end else begin
        head_group = pending_groups.pop_front();
        check_field("group_count", head_group.group_count, group_count_o);
        check_field("print_with_count", head_group.print_with_count, print_with_count_o);
        check_field("print_line", head_group.print_line, print_line_o);
        check_field("key_truncated", head_group.key_truncated, key_truncated_o);
      end
    end
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c == aldd_pkg::CharSpace || (c >= aldd_pkg::CharTab && c <= aldd_pkg::CharCr);
  endfunction

  function automatic aldd_pkg::result_t group_summary();
    aldd_pkg::result_t r;
    r.group_count = group_lines;
    r.print_with_count = reg_count_mode;
    r.print_line = !reg_count_mode &&
                   ((reg_show_rep && group_lines > 1) || (reg_show_uniq && group_lines == 1));
    r.key_truncated = group_trunc;
    return r;
  endfunction

  function automatic void open_line();
    key_len = 0;
    key_mismatch = 1'b0;
    line_trunc = 1'b0;
    in_word = 1'b0;
    skip_field_cnt = reg_skip_fields;
    skip_char_cnt = reg_skip_chars;
  endfunction

  function automatic void dedup_predict(input logic [7:0] c, input bit le, input bit se);
    int unsigned old_base;
    int unsigned new_base;
    if (se) begin
      if (have_group) pending_groups.push_back(group_summary());
      bank_sel = 1'b0;
      stored_len = 0;
      group_lines = '0;
      have_group = 1'b0;
      group_trunc = 1'b0;
      open_line();
      return;
    end
    old_base = bank_sel ? LineCap : 0;
    new_base = bank_sel ? 0 : LineCap;
    if (skip_field_cnt != 0) begin
      if (is_blank(c)) begin
        if (in_word) begin
          in_word = 1'b0;
          skip_field_cnt--;
        end
      end else begin
        in_word = 1'b1;
      end
    end else if (skip_char_cnt != 0) begin
      skip_char_cnt--;
    end else if (key_len >= LineCap) begin
      line_trunc = 1'b1;
    end else begin
      if (!(key_len < stored_len && key_mem[old_base + key_len] == c)) key_mismatch = 1'b1;
      key_mem[new_base + key_len] = c;
      key_len++;
    end
    if (le) begin
      if (!have_group || key_mismatch || key_len != stored_len) begin
        if (have_group) pending_groups.push_back(group_summary());
        bank_sel = !bank_sel;
        stored_len = key_len;
        group_lines = 32'd1;
        group_trunc = line_trunc;
        have_group = 1'b1;
      end else begin
        if (group_lines != 32'hFFFF_FFFF) group_lines++;
        if (line_trunc) group_trunc = 1'b1;
      end
      open_line();
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input bit le, input bit se);
    @(negedge clk_i);
    while (tx_idle_on && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    line_end_i <= le;
    stream_end_i <= se;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    dedup_predict(c, le, se);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, 1'b0);
  endtask

  task automatic send_run(input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) send_byte(c, 1'b0, 1'b0);
  endtask

  task automatic drain();
    int waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_groups.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_groups.size() != 0) begin
      mismatches++;
      $display("t=%0t: %0d group results expected, actual none", $time,
               pending_groups.size());
      pending_groups.delete();
    end
    // give a byte that closes no group time to leave the pipeline
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input aldd_pkg::cfg_idx_e idx,
                           input logic [aldd_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      aldd_pkg::CFG_COUNT_MODE:    reg_count_mode = val[0];
      aldd_pkg::CFG_SHOW_REPEATED: reg_show_rep = val[0];
      aldd_pkg::CFG_SHOW_UNIQUE:   reg_show_uniq = val[0];
      aldd_pkg::CFG_SKIP_FIELDS:   reg_skip_fields = val;
      aldd_pkg::CFG_SKIP_CHARS:    reg_skip_chars = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write all registers, then flush so the new skip counts load at once
  task automatic apply_config(input bit cm, input bit sr, input bit su,
                              input logic [11:0] sf, input logic [11:0] sc);
    drain();
    cfg_write(aldd_pkg::CFG_COUNT_MODE, {11'b0, cm});
    cfg_write(aldd_pkg::CFG_SHOW_REPEATED, {11'b0, sr});
    cfg_write(aldd_pkg::CFG_SHOW_UNIQUE, {11'b0, su});
    cfg_write(aldd_pkg::CFG_SKIP_FIELDS, sf);
    cfg_write(aldd_pkg::CFG_SKIP_CHARS, sc);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_stream_marks();
    // flush of an empty stream, then of a lone unfinished line
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte("q", 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_text("a\n");
    send_text("a\n");
    send_text("b\n");
    // stream end wins over line end
    send_byte("x", 1'b1, 1'b1);
    send_text("c\n");
    send_run("d", 2);
    send_byte(8'hFF, 1'b0, 1'b1);
    repeat (2) begin
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(LineFeed, 1'b1, 1'b0);
    end
    send_byte("x", 1'b1, 1'b0);
    send_byte(LineFeed, 1'b1, 1'b0);
    send_byte(LineFeed, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic mode_groups();
    repeat (3) send_text("p\n");
    send_text("q\n");
    repeat (2) send_text("r\n");
    send_text("s\n");
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_print_modes();
    apply_config(1'b1, 1'b1, 1'b1, 12'd0, 12'd0);
    mode_groups();
    apply_config(1'b1, 1'b0, 1'b0, 12'd0, 12'd0);
    mode_groups();
    apply_config(1'b0, 1'b1, 1'b0, 12'd0, 12'd0);
    mode_groups();
    apply_config(1'b0, 1'b0, 1'b1, 12'd0, 12'd0);
    mode_groups();
    apply_config(1'b0, 1'b0, 1'b0, 12'd0, 12'd0);
    mode_groups();
  endtask

  task automatic test_field_skip();
    apply_config(1'b0, 1'b1, 1'b1, 12'd1, 12'd0);
    send_text("one same\n");
    send_text("two same\n");
    send_text("  lead\tsame\n");
    send_text("x\013same\n");
    send_text("y\015same\n");
    send_text("z\014same\n");
    send_text("\n");
    send_text("word\n");
    apply_config(1'b0, 1'b1, 1'b1, 12'd2, 12'd3);
    send_text("a b xyzKEY\n");
    send_text("c d 123KEY\n");
    // change the char skip mid-stream; the next line still uses the old count
    drain();
    cfg_write(aldd_pkg::CFG_SKIP_CHARS, 12'd0);
    send_text("e f 999KEY\n");
    send_text("g h KEY\n");
    send_text("g h 1KEY\n");
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_skip_limits();
    apply_config(1'b0, 1'b1, 1'b0, 12'd2048, 12'd0);
    send_text("a b c\n");
    send_text("x\ty\n");
    send_text("\n");
    apply_config(1'b0, 1'b1, 1'b1, 12'd2048, 12'd2048);
    send_text("p q\n");
    send_text("r\n");
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_output_stall();
    apply_config(1'b0, 1'b1, 1'b1, 12'd0, 12'd0);
    // hold the result side while distinct lines keep closing groups
    stall_req = 400;
    for (int i = 0; i < 40; i++) send_text($sformatf("line%0d\n", i));
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_text();
    logic [7:0]  body [4][8];
    int          body_len [4];
    string       glyphs = "ab \t";
    int          sent;
    int          pick;
    int          kind;
    int          len;
    int          n_pref;
    int          r;
    logic [11:0] sf;
    logic [11:0] sc;
    for (int ph = 0; ph < 6; ph++) begin
      r = $urandom_range(0, 9);
      sf = (r < 8) ? 12'(r % 4) : 12'd2048;
      r = $urandom_range(0, 9);
      sc = (r < 8) ? 12'(r % 5) : 12'd2048;
      apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), sf, sc);
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      for (int b = 0; b < 4; b++) begin
        body_len[b] = $urandom_range(0, 7);
        for (int k = 0; k < 8; k++)
          body[b][k] = ($urandom_range(0, 9) < 7) ? glyphs[$urandom_range(0, 3)]
                                                  : 8'($urandom_range(0, 255));
      end
      sent = 0;
      pick = 0;
      while (sent < 110) begin
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
          if ($urandom_range(0, 1)) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
              send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            sent += len;
          end
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
          sent++;
        end else if (kind < 15) begin
          len = $urandom_range(1, 10);
          for (int k = 0; k < len; k++)
            send_byte(8'($urandom_range(0, 255)), k == len - 1, 1'b0);
          sent += len;
        end else begin
          // well-formed line: skipped words, skipped bytes, then a pooled body
          if ($urandom_range(0, 99) >= 60) pick = $urandom_range(0, 3);
          n_pref = (reg_skip_fields > 12'd3) ? 2 : int'(reg_skip_fields);
          for (int w = 0; w < n_pref; w++) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
              send_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0, 1'b0);
            send_byte($urandom_range(0, 1) ? aldd_pkg::CharSpace : aldd_pkg::CharTab,
                      1'b0, 1'b0);
            sent += len + 1;
          end
          if (reg_skip_chars <= 12'd4) begin
            for (int k = 0; k < int'(reg_skip_chars); k++)
              send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            sent += int'(reg_skip_chars);
          end
          for (int k = 0; k < body_len[pick]; k++) send_byte(body[pick][k], 1'b0, 1'b0);
          send_byte(LineFeed, 1'b1, 1'b0);
          sent += body_len[pick] + 1;
        end
      end
      send_byte(8'h00, 1'b0, 1'b1);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_stream_marks();
    test_print_modes();
    test_field_skip();
    test_skip_limits();
    test_output_stall();
    test_random_text();
    drain();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
